/* rtl/core/slpd_pkg.sv */
// shared types and constants for the short/long press decoder
// no dependencies

package slpd_pkg;

  localparam int unsigned LEVEL_W       = 4;     // width of the switch level field
  localparam int unsigned TIME_W        = 32;    // millisecond timestamp width
  localparam int unsigned THR_W         = 16;    // threshold register width
  localparam int unsigned EVT_W         = 4;     // event code width
  localparam int unsigned NUM_SW_DEF    = 4;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 2;

  localparam logic [THR_W-1:0]      THR_RESET = 16'd3000;
  localparam logic [APB_ADDR_W-1:0] ADDR_THR  = 2'd0;
  localparam logic [EVT_W-1:0]      EVT_NONE  = 4'd0;

  // per-switch event flags for one poll
  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } sw_hit_t;

endpackage

/* rtl/core/slpd_chan.sv */
// press tracker for a single switch: pressed flag, start time, long-issued flag
// depends on slpd_pkg

module slpd_chan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        down,
  input  logic [slpd_pkg::TIME_W-1:0] now,
  input  logic [slpd_pkg::THR_W-1:0]  thr,
  output slpd_pkg::sw_hit_t           hit
);
  import slpd_pkg::*;

  logic              active;
  logic              sent;
  logic [TIME_W-1:0] start;
  logic              active_next;
  logic              sent_next;
  logic [TIME_W-1:0] held;
  logic              held_long;

  // elapsed time wraps modulo 2^32
  assign held      = now - start;
  assign held_long = held >= {{(TIME_W-THR_W){1'b0}}, thr};

  always_comb begin
    active_next   = active;
    sent_next     = sent;
    hit.short_hit = 1'b0;
    hit.long_hit  = 1'b0;
    if (down && !active) begin
      active_next = 1'b1;
      sent_next   = 1'b0;
    end else if (!down && active) begin
      hit.short_hit = !sent;
      active_next   = 1'b0;
      sent_next     = 1'b0;
    end else if (down && !sent && held_long) begin
      hit.long_hit = 1'b1;
      sent_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      sent   <= 1'b0;
      start  <= '0;
    end else if (en) begin
      active <= active_next;
      sent   <= sent_next;
      if (down && !active) begin
        start <= now;
      end
    end
  end

endmodule

/* rtl/core/short_long_press_decoder_core.sv */
// top level of the short/long press decoder: input register, per-switch trackers,
// highest-switch priority select and result register; depends on slpd_pkg, slpd_chan
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------
//  poll in | in_valid/in_stall  | switch_levels, now_ms
//  event   | out_valid/out_stall| button_event
//  config  | apb psel/penable   | paddr, pwdata, prdata
//
// one poll per cycle while the result is not stalled; a poll passes the input register, then the result register
// the trackers update in the cycle a registered poll moves into the result register
// synchronous reset clears all press state and loads the threshold with 3000 ms
// a stalled result freezes the result register and a full input stage; in_stall rises only when the input stage is full

module short_long_press_decoder_core #(
  parameter int unsigned NUM_SWITCHES = slpd_pkg::NUM_SW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slpd_pkg::LEVEL_W-1:0]    switch_levels,
  input  logic [slpd_pkg::TIME_W-1:0]     now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slpd_pkg::EVT_W-1:0]      button_event,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slpd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [slpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [slpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import slpd_pkg::*;

  logic               s1_valid;
  logic [LEVEL_W-1:0] s1_levels;
  logic [TIME_W-1:0]  s1_now;
  logic [THR_W-1:0]   thr;
  logic               adv;
  logic               proc;
  logic               s1_load;
  sw_hit_t            hits [NUM_SWITCHES];
  logic [EVT_W-1:0]   evt_next;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THR) ? {{(APB_DATA_W-THR_W){1'b0}}, thr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_THR)) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  // pipeline control
  assign adv      = !out_valid || !out_stall;
  assign proc     = s1_valid && adv;
  assign in_stall = s1_valid && !adv;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_levels <= switch_levels;
      s1_now    <= now_ms;
    end
  end

  // one tracker per switch; switches past the level field stay released
  for (genvar k = 0; k < NUM_SWITCHES; k++) begin : g_sw
    logic down;
    if (k < LEVEL_W) begin : g_in
      assign down = s1_levels[k];
    end else begin : g_off
      assign down = 1'b0;
    end
    slpd_chan u_chan (
      .clk  (clk),
      .rst  (rst),
      .en   (proc),
      .down (down),
      .now  (s1_now),
      .thr  (thr),
      .hit  (hits[k])
    );
  end

  // highest-numbered switch wins
  always_comb begin
    evt_next = EVT_NONE;
    for (int k = 0; k < NUM_SWITCHES; k++) begin
      if (hits[k].short_hit) begin
        evt_next = EVT_W'(1 + k);
      end else if (hits[k].long_hit) begin
        evt_next = EVT_W'(1 + NUM_SWITCHES + k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      button_event <= evt_next;
    end
  end

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_poll_reaches_output: assert property (@(posedge clk) disable iff (rst)
    proc |=> out_valid)
    else $error("processed poll did not produce a result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(button_event)))
    else $error("stalled result changed");

  a_thr_reset: assert property (@(posedge clk)
    rst |=> (thr == THR_RESET))
    else $error("threshold not at reset value");
`endif

endmodule
